// File: sv/steepest_descent_direction_3x3_assert.svh
// Assertion macros used by the checker of this block.
`ifndef STEEPEST_DESCENT_DIRECTION_3X3_ASSERT_SVH
`define STEEPEST_DESCENT_DIRECTION_3X3_ASSERT_SVH

// Same-cycle implication under reset.
`define SDD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define SDD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/sdd_pkg.sv
package sdd_pkg;

    localparam int MAX_COLUMNS_DEFAULT = 1024;
    localparam int SAMPLE_BITS_DEFAULT = 32;

    localparam int NUM_COLUMNS_BITS  = 11;
    localparam int ROW_BITS          = 16;
    localparam int CFG_DATA_BITS     = 16;
    localparam int CFG_INDEX_BITS    = 2;
    localparam int DIR_BITS          = 4;

    localparam logic [NUM_COLUMNS_BITS-1:0] NUM_COLUMNS_RESET = NUM_COLUMNS_BITS'(1024);
    localparam logic [ROW_BITS-1:0]         NUM_ROWS_RESET    = ROW_BITS'(1024);
    localparam int MIN_SIZE = 3;

    // Window cells, numbered row-major; the centre sits in the middle.
    localparam int WINDOW_CELLS = 9;
    localparam int CENTER_CODE  = 4;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_NUM_COLUMNS = 2'd0,
        REG_NUM_ROWS    = 2'd1
    } cfg_reg_t;

    // Per-item classification handed from front to back.
    typedef struct packed {
        logic                emit;
        logic                last;
        logic [ROW_BITS-1:0] center_row;
    } sdd_tag_t;

endpackage

// File: sv/sdd_queue.sv
module sdd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sdd_pkg::QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEVEL_BITS = $clog2(DEPTH+1);

    logic [WIDTH-1:0]      slot_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LEVEL_BITS-1:0] level_reg, level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = slot_reg[rd_ptr_reg];
    assign level    = level_reg;

endmodule

// File: sv/sdd_front.sv
module sdd_front #(
    parameter int MAX_COLUMNS = sdd_pkg::MAX_COLUMNS_DEFAULT,
    parameter int SAMPLE_BITS = sdd_pkg::SAMPLE_BITS_DEFAULT,
    parameter int PUSH_BITS   = 8
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      write_enable,
    input  logic [sdd_pkg::CFG_INDEX_BITS-1:0]        write_index,
    input  logic [sdd_pkg::CFG_DATA_BITS-1:0]         write_data,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic signed [SAMPLE_BITS-1:0]             sample,
    input  logic                                      frame_start,
    input  logic [$clog2(sdd_pkg::QUEUE_DEPTH+1)-1:0] q_level,
    output logic                                      push,
    output logic [PUSH_BITS-1:0]                      push_data
);

    localparam int COL_BITS  = $clog2(MAX_COLUMNS);
    localparam int ROW_BITS  = sdd_pkg::ROW_BITS;
    localparam int PAIR_BITS = 2 * SAMPLE_BITS;

    logic [sdd_pkg::NUM_COLUMNS_BITS-1:0] num_columns_reg;
    logic [ROW_BITS-1:0]                  num_rows_reg;
    logic [COL_BITS-1:0]                  cols_m1;
    logic [ROW_BITS-1:0]                  rows_m1;

    logic [COL_BITS-1:0] col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [COL_BITS-1:0] c0, c1;
    logic [ROW_BITS-1:0] r0, r1, rr;
    logic                accept;
    sdd_pkg::sdd_tag_t   tag;

    // Each column keeps {upper row, middle row} in one word.
    logic [PAIR_BITS-1:0] pair_mem [MAX_COLUMNS];
    logic [PAIR_BITS-1:0] rd_pair_reg;
    logic [PAIR_BITS-1:0] fwd_pair_reg;
    logic                 fwd_reg;
    logic [PAIR_BITS-1:0] pair;

    logic                          s2_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s2_key_reg;
    logic [COL_BITS-1:0]           s2_col_reg;
    logic [COL_BITS-1:0]           s2_ccol_reg;
    sdd_pkg::sdd_tag_t             s2_tag_reg;
    logic [SAMPLE_BITS-1:0]        top, mid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_columns_reg <= sdd_pkg::NUM_COLUMNS_RESET;
            num_rows_reg    <= sdd_pkg::NUM_ROWS_RESET;
        end
        else if (write_enable)
        begin
            case (write_index)
                sdd_pkg::REG_NUM_COLUMNS:
                    num_columns_reg <= write_data[sdd_pkg::NUM_COLUMNS_BITS-1:0];
                sdd_pkg::REG_NUM_ROWS:
                    num_rows_reg <= write_data[ROW_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    // Clamp the sizes, kept as last index.
    always_comb
    begin
        if (num_columns_reg < sdd_pkg::NUM_COLUMNS_BITS'(sdd_pkg::MIN_SIZE))
        begin
            cols_m1 = COL_BITS'(sdd_pkg::MIN_SIZE - 1);
        end
        else if (32'(num_columns_reg) > 32'(MAX_COLUMNS))
        begin
            cols_m1 = COL_BITS'(MAX_COLUMNS - 1);
        end
        else
        begin
            cols_m1 = COL_BITS'(num_columns_reg - 1'b1);
        end
        if (num_rows_reg < ROW_BITS'(sdd_pkg::MIN_SIZE))
        begin
            rows_m1 = ROW_BITS'(sdd_pkg::MIN_SIZE - 1);
        end
        else
        begin
            rows_m1 = num_rows_reg - 1'b1;
        end
    end

    // Reserve a slot for the beat already in stage two.
    assign in_stall = (int'(q_level) + int'(s2_valid_reg)) >= sdd_pkg::QUEUE_DEPTH;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        c0 = frame_start ? '0 : col_reg;
        r0 = frame_start ? '0 : row_reg;
        if (c0 > cols_m1)
        begin
            c1 = '0;
            r1 = r0 + 1'b1;
        end
        else
        begin
            c1 = c0;
            r1 = r0;
        end
        rr = (r1 > rows_m1) ? '0 : r1;

        if (c1 == cols_m1)
        begin
            col_next = '0;
            row_next = (rr == rows_m1) ? '0 : rr + 1'b1;
        end
        else
        begin
            col_next = c1 + 1'b1;
            row_next = rr;
        end

        tag.emit       = (rr >= ROW_BITS'(2)) && (c1 >= COL_BITS'(2));
        tag.last       = (rr == rows_m1) && (c1 == cols_m1);
        tag.center_row = rr - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s2_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= accept;
            fwd_reg      <= accept && s2_valid_reg && (s2_col_reg == c1);
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_pair_reg <= pair_mem[c1];
            s2_key_reg  <= sample;
            s2_col_reg  <= c1;
            s2_ccol_reg <= c1 - 1'b1;
            s2_tag_reg  <= tag;
        end
        fwd_pair_reg <= {mid, s2_key_reg};
        if (s2_valid_reg)
        begin
            pair_mem[s2_col_reg] <= {mid, s2_key_reg};
        end
    end

    // Take the write of the previous beat when it hit the same column.
    assign pair = fwd_reg ? fwd_pair_reg : rd_pair_reg;
    assign top  = pair[PAIR_BITS-1:SAMPLE_BITS];
    assign mid  = pair[SAMPLE_BITS-1:0];

    assign push      = s2_valid_reg;
    assign push_data = {s2_tag_reg, s2_ccol_reg, top, mid, s2_key_reg};

endmodule

// File: sv/sdd_back.sv
module sdd_back #(
    parameter int MAX_COLUMNS = sdd_pkg::MAX_COLUMNS_DEFAULT,
    parameter int SAMPLE_BITS = sdd_pkg::SAMPLE_BITS_DEFAULT,
    parameter int PUSH_BITS   = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  logic [PUSH_BITS-1:0]                q_data,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sdd_pkg::DIR_BITS-1:0]        direction,
    output logic [sdd_pkg::ROW_BITS-1:0]        center_row,
    output logic [$clog2(MAX_COLUMNS)-1:0]      center_column,
    output logic                                last
);

    localparam int COL_BITS = $clog2(MAX_COLUMNS);
    localparam int DIR_BITS = sdd_pkg::DIR_BITS;
    localparam int CELLS    = sdd_pkg::WINDOW_CELLS;
    localparam int CENTER   = sdd_pkg::CENTER_CODE;

    sdd_pkg::sdd_tag_t             tag;
    logic [COL_BITS-1:0]           ccol;
    logic signed [SAMPLE_BITS-1:0] top, mid, key;

    logic signed [SAMPLE_BITS-1:0] win_reg [6];
    logic signed [SAMPLE_BITS-1:0] win [CELLS];

    logic signed [SAMPLE_BITS-1:0] v0 [CELLS];
    logic [DIR_BITS-1:0]           d0 [CELLS];
    logic signed [SAMPLE_BITS-1:0] v1 [4];
    logic [DIR_BITS-1:0]           d1 [4];
    logic signed [SAMPLE_BITS-1:0] v2 [2];
    logic [DIR_BITS-1:0]           d2 [2];
    logic signed [SAMPLE_BITS-1:0] v3;
    logic [DIR_BITS-1:0]           d3;
    logic [DIR_BITS-1:0]           best;

    logic                out_valid_reg;
    logic [DIR_BITS-1:0] direction_reg;
    logic [sdd_pkg::ROW_BITS-1:0] center_row_reg;
    logic [COL_BITS-1:0] center_column_reg;
    logic                last_reg;

    assign {tag, ccol, top, mid, key} = q_data;

    // Window in code order: left column, held column, new column.
    assign win[0] = win_reg[0];
    assign win[1] = win_reg[3];
    assign win[2] = top;
    assign win[3] = win_reg[1];
    assign win[4] = win_reg[4];
    assign win[5] = mid;
    assign win[6] = win_reg[2];
    assign win[7] = win_reg[5];
    assign win[8] = key;

    // Scan order puts the centre first; each pair keeps the left on ties.
    always_comb
    begin
        for (int k = 0; k < CELLS; k++)
        begin
            if (k < CENTER)
            begin
                v0[k+1] = win[k];
                d0[k+1] = DIR_BITS'(k);
            end
            else if (k > CENTER)
            begin
                v0[k] = win[k];
                d0[k] = DIR_BITS'(k);
            end
            else
            begin
                v0[0] = win[k];
                d0[0] = DIR_BITS'(k);
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            if (v0[2*i+1] < v0[2*i])
            begin
                v1[i] = v0[2*i+1];
                d1[i] = d0[2*i+1];
            end
            else
            begin
                v1[i] = v0[2*i];
                d1[i] = d0[2*i];
            end
        end
        for (int i = 0; i < 2; i++)
        begin
            if (v1[2*i+1] < v1[2*i])
            begin
                v2[i] = v1[2*i+1];
                d2[i] = d1[2*i+1];
            end
            else
            begin
                v2[i] = v1[2*i];
                d2[i] = d1[2*i];
            end
        end
        if (v2[1] < v2[0])
        begin
            v3 = v2[1];
            d3 = d2[1];
        end
        else
        begin
            v3 = v2[0];
            d3 = d2[0];
        end
        best = (v0[CELLS-1] < v3) ? d0[CELLS-1] : d3;
    end

    assign pop = q_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= tag.emit;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= key;
            if (tag.emit)
            begin
                direction_reg     <= best;
                center_row_reg    <= tag.center_row;
                center_column_reg <= ccol;
                last_reg          <= tag.last;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign direction     = direction_reg;
    assign center_row    = center_row_reg;
    assign center_column = center_column_reg;
    assign last          = last_reg;

endmodule

// File: sv/steepest_descent_direction_3x3.sv
// Steepest-descent direction over a 3x3 window. Samples enter in raster order at one
// beat per cycle while in_valid is high and in_stall low; for each interior cell the block
// returns the code 0..8 of its lowest neighbor (row-major, 4 is the cell itself, ties to
// the centre and then the lowest code), with the cell's row and column and a flag on the
// last interior cell. An accepted sample passes the row-store read into the stage-two
// registers, is written back and enqueued, then goes through the compare tree into the
// output register. The rate of one beat per cycle while nothing stalls is set by the
// row store, a single memory of {upper, middle} pairs per column that is read and
// written at most once each cycle; a four-entry queue sits between the store and the
// compare stage. No clearing pass runs after reset. The user must write sizes through
// the register port only while the block is idle; the block itself does not enforce it.
module steepest_descent_direction_3x3 #(
    parameter int MAX_COLUMNS = sdd_pkg::MAX_COLUMNS_DEFAULT,
    parameter int SAMPLE_BITS = sdd_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               write_enable,
    input  logic [sdd_pkg::CFG_INDEX_BITS-1:0] write_index,
    input  logic [sdd_pkg::CFG_DATA_BITS-1:0]  write_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [SAMPLE_BITS-1:0]      sample,
    input  logic                               frame_start,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [sdd_pkg::DIR_BITS-1:0]       direction,
    output logic [sdd_pkg::ROW_BITS-1:0]       center_row,
    output logic [$clog2(MAX_COLUMNS)-1:0]     center_column,
    output logic                               last
);

    localparam int COL_BITS   = $clog2(MAX_COLUMNS);
    localparam int PUSH_BITS  = $bits(sdd_pkg::sdd_tag_t) + COL_BITS + 3 * SAMPLE_BITS;
    localparam int LEVEL_BITS = $clog2(sdd_pkg::QUEUE_DEPTH+1);

    logic                  push;
    logic [PUSH_BITS-1:0]  push_data;
    logic                  pop;
    logic [PUSH_BITS-1:0]  pop_data;
    logic [LEVEL_BITS-1:0] q_level;

    sdd_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .PUSH_BITS   (PUSH_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .frame_start  (frame_start),
        .q_level      (q_level),
        .push         (push),
        .push_data    (push_data)
    );

    sdd_queue #(
        .WIDTH (PUSH_BITS),
        .DEPTH (sdd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .level     (q_level)
    );

    sdd_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .PUSH_BITS   (PUSH_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_level != '0),
        .q_data        (pop_data),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .direction     (direction),
        .center_row    (center_row),
        .center_column (center_column),
        .last          (last)
    );

endmodule

// File: sv/sdd_checker.sv
`include "steepest_descent_direction_3x3_assert.svh"

module sdd_checker #(
    parameter int MAX_COLUMNS = sdd_pkg::MAX_COLUMNS_DEFAULT
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [sdd_pkg::DIR_BITS-1:0]   direction,
    input logic [sdd_pkg::ROW_BITS-1:0]   center_row,
    input logic [$clog2(MAX_COLUMNS)-1:0] center_column,
    input logic                           last
);

    localparam int COL_BITS = $clog2(MAX_COLUMNS);

    // Hold a stalled result beat.
    `SDD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(direction) && $stable(center_row) && $stable(center_column) && $stable(last), "result beat changed while stalled")

    `SDD_ASSERT_NOW(a_dir_range, clk, rst_n, out_valid, direction <= sdd_pkg::DIR_BITS'(sdd_pkg::WINDOW_CELLS - 1), "direction code out of range")

    // Border cells never produce a beat.
    `SDD_ASSERT_NOW(a_col_interior, clk, rst_n, out_valid, center_column != '0 && center_column <= COL_BITS'(MAX_COLUMNS - 2), "result column on the border")

    `SDD_ASSERT_NOW(a_row_interior, clk, rst_n, out_valid, center_row != '0 && center_row != '1, "result row on the border")

endmodule

bind steepest_descent_direction_3x3 sdd_checker #(
    .MAX_COLUMNS (MAX_COLUMNS)
) u_sdd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .direction     (direction),
    .center_row    (center_row),
    .center_column (center_column),
    .last          (last)
);
